// ----- rtl/gmd_pkg.sv -----
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared constants and types of the grid maze depth-first walker.
// ----------------------------------------------------------------------------
package gmd_pkg;

  // grid geometry
  localparam int MAX_DIM = 64;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int CNT_W   = ADDR_W + 1;

  // word field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // cell map entry: bit 1 visited, bit 0 open
  localparam int CELL_W    = 2;
  localparam int CELL_OPEN = 0;
  localparam int CELL_VIS  = 1;

  // neighbours per step: west, east, north, south
  localparam int NBR_CNT = 4;
  localparam int NBR_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOOKING = 2'd0,
    ST_FREEDOM = 2'd1,
    ST_STUCK   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAZE_WIDTH  = 3'd0,
    REG_MAZE_HEIGHT = 3'd1,
    REG_EXIT_X      = 3'd2,
    REG_EXIT_Y      = 3'd3,
    REG_START_X     = 3'd4,
    REG_START_Y     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SWEEP,
    S_POP,
    S_NBR,
    S_DONE
  } state_e;

endpackage

// ----- rtl/gmd_if.sv -----
// ----------------------------------------------------------------------------
// gmd_if
// Valid/ready channels of the maze walker: commands, results, register writes.
// ----------------------------------------------------------------------------
interface gmd_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [gmd_pkg::CMD_W-1:0]   command;
  logic [gmd_pkg::COORD_W-1:0] cell_x;
  logic [gmd_pkg::COORD_W-1:0] cell_y;
  logic                       cell_open;

  modport source (output valid, command, cell_x, cell_y, cell_open, input ready);
  modport sink   (input valid, command, cell_x, cell_y, cell_open, output ready);
endinterface

interface gmd_res_if;
  logic                        valid;
  logic                        ready;
  logic [gmd_pkg::STATUS_W-1:0] status;
  logic [gmd_pkg::COORD_W-1:0]  pos_x;
  logic [gmd_pkg::COORD_W-1:0]  pos_y;
  logic [gmd_pkg::CNT_W-1:0]    pending;

  modport source (output valid, status, pos_x, pos_y, pending, input ready);
  modport sink   (input valid, status, pos_x, pos_y, pending, output ready);
endinterface

interface gmd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gmd_pkg::CFG_IDX_W-1:0]  index;
  logic [gmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gmd_ram.sv -----
// ----------------------------------------------------------------------------
// gmd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/grid_maze_dfs_step.sv -----
// ----------------------------------------------------------------------------
// grid_maze_dfs_step
// Depth-first walker over a grid maze held in a cell map RAM and a point stack.
// ----------------------------------------------------------------------------
// one command at a time, the next taken only once the walker is back in its idle state;
//   result word registered, next command taken while it waits
// load: read-modify-write of the cell map entry
// step: no stack read on empty stack, only the pop read on the exit, else pop read + 4 pipelined reads
// start: a sweep that clears every visited bit but the start cell's through the cell map port
// after reset: clearing pass over every cell map entry before the first command
module grid_maze_dfs_step (
  input  logic clk_i,
  input  logic rst_ni,
  gmd_cmd_if.sink   cmd_i,
  gmd_res_if.source res_o,
  gmd_cfg_if.sink   cfg_i
);

  localparam int AW = gmd_pkg::ADDR_W;
  localparam int CW = gmd_pkg::COORD_W;
  localparam int NW = gmd_pkg::CNT_W;
  localparam int DW = gmd_pkg::DIM_W;

  // control state
  gmd_pkg::state_e  state_q, state_d;
  gmd_pkg::status_e status_q, status_d;
  logic [NW-1:0]    sw_q, sw_d;
  logic [gmd_pkg::NBR_W-1:0] nb_q, nb_d;
  logic             chk_v_q, chk_v_d;
  logic             chk_ok_q, chk_ok_d;
  logic [AW-1:0]    chk_addr_q, chk_addr_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             res_vld_q, res_vld_d;

  // payload registers
  logic [AW-1:0]    ld_addr_q, ld_addr_d;
  logic             ld_open_q, ld_open_d;
  logic [gmd_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [AW-1:0]    res_pos_q, res_pos_d;
  logic [NW-1:0]    res_cnt_q, res_cnt_d;

  // configuration registers
  logic [DW-1:0] width_q, height_q;
  logic [CW-1:0] exit_x_q, exit_y_q, start_x_q, start_y_q;

  // memory ports
  logic                       map_we;
  logic [AW-1:0]              map_waddr, map_raddr;
  logic [gmd_pkg::CELL_W-1:0] map_wdata, map_rdata;
  logic                       stk_we;
  logic [AW-1:0]              stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // neighbour address generation
  logic [DW-1:0] nx, ny;
  logic          n_dir_ok, n_ok;
  logic          cmd_acc, res_free;
  logic [AW-1:0] start_addr, sw_waddr;
  logic          nbr_push;

  assign cmd_acc    = cmd_i.valid && cmd_i.ready;
  assign res_free   = !res_vld_q || res_o.ready;
  assign start_addr = {start_y_q, start_x_q};
  assign sw_waddr   = AW'(sw_q - NW'(1));

  // cell map: open and visited bits of every cell
  gmd_ram #(
    .WIDTH (gmd_pkg::CELL_W),
    .DEPTH (gmd_pkg::CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // point stack, entries are {y, x}
  gmd_ram #(
    .WIDTH (AW),
    .DEPTH (gmd_pkg::CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // neighbour of the current position selected by nb_q
  always_comb begin
    nx       = {1'b0, pos_q[CW-1:0]};
    ny       = {1'b0, pos_q[AW-1:CW]};
    n_dir_ok = 1'b1;
    unique case (nb_q)
      3'd0: begin
        n_dir_ok = (pos_q[CW-1:0] != '0);
        nx       = nx - DW'(1);
      end
      3'd1: nx = nx + DW'(1);
      3'd2: begin
        n_dir_ok = (pos_q[AW-1:CW] != '0);
        ny       = ny - DW'(1);
      end
      3'd3: ny = ny + DW'(1);
      default: n_dir_ok = 1'b0;
    endcase
    n_ok = n_dir_ok && (nx < DW'(gmd_pkg::MAX_DIM)) && (ny < DW'(gmd_pkg::MAX_DIM))
           && (nx < width_q) && (ny < height_q);
  end

  // candidate from the previous cycle is open and not yet visited
  assign nbr_push = chk_v_q && chk_ok_q && map_rdata[gmd_pkg::CELL_OPEN]
                    && !map_rdata[gmd_pkg::CELL_VIS];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gmd_pkg::S_CLEAR: begin
        if (sw_q == NW'(gmd_pkg::CELLS - 1)) state_d = gmd_pkg::S_IDLE;
      end
      gmd_pkg::S_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd_i.command)
            gmd_pkg::CMD_LOAD:  state_d = gmd_pkg::S_LOAD;
            gmd_pkg::CMD_START: state_d = gmd_pkg::S_SWEEP;
            gmd_pkg::CMD_STEP: begin
              state_d = (cnt_q == '0) ? gmd_pkg::S_DONE : gmd_pkg::S_POP;
            end
            default: state_d = gmd_pkg::S_DONE;
          endcase
        end
      end
      gmd_pkg::S_LOAD: state_d = gmd_pkg::S_DONE;
      gmd_pkg::S_SWEEP: begin
        if (sw_q == NW'(gmd_pkg::CELLS)) state_d = gmd_pkg::S_DONE;
      end
      gmd_pkg::S_POP: begin
        state_d = (stk_rdata == {exit_y_q, exit_x_q}) ? gmd_pkg::S_DONE : gmd_pkg::S_NBR;
      end
      gmd_pkg::S_NBR: begin
        if (nb_q == gmd_pkg::NBR_W'(gmd_pkg::NBR_CNT)) state_d = gmd_pkg::S_DONE;
      end
      gmd_pkg::S_DONE: begin
        if (res_free) state_d = gmd_pkg::S_IDLE;
      end
      default: state_d = gmd_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    status_d     = status_q;
    sw_d         = sw_q;
    nb_d         = nb_q;
    chk_v_d      = 1'b0;
    chk_ok_d     = chk_ok_q;
    chk_addr_d   = chk_addr_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    ld_addr_d    = ld_addr_q;
    ld_open_d    = ld_open_q;
    res_vld_d    = res_vld_q && !res_o.ready;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_cnt_d    = res_cnt_q;
    map_we       = 1'b0;
    map_waddr    = ld_addr_q;
    map_wdata    = '0;
    map_raddr    = {cmd_i.cell_y, cmd_i.cell_x};
    stk_we       = 1'b0;
    stk_waddr    = cnt_q[AW-1:0];
    stk_wdata    = chk_addr_q;
    stk_raddr    = AW'(cnt_q - NW'(1));
    unique case (state_q)
      gmd_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = sw_q[AW-1:0];
        sw_d      = (sw_q == NW'(gmd_pkg::CELLS - 1)) ? '0 : sw_q + NW'(1);
      end
      gmd_pkg::S_IDLE: begin
        if (cmd_acc) begin
          ld_addr_d = {cmd_i.cell_y, cmd_i.cell_x};
          ld_open_d = cmd_i.cell_open;
          sw_d      = '0;
          nb_d      = '0;
          if (cmd_i.command == gmd_pkg::CMD_STEP) begin
            if (cnt_q == '0) status_d = gmd_pkg::ST_STUCK;
            else cnt_d = cnt_q - NW'(1);
          end
        end
      end
      gmd_pkg::S_LOAD: begin
        // keep the visited bit, replace the open bit
        map_we    = 1'b1;
        map_wdata = {map_rdata[gmd_pkg::CELL_VIS], ld_open_q};
      end
      gmd_pkg::S_SWEEP: begin
        // read entry sw_q, write back entry sw_q-1 with only the start marked
        map_raddr = sw_q[AW-1:0];
        map_we    = (sw_q != '0);
        map_waddr = sw_waddr;
        map_wdata = {sw_waddr == start_addr, map_rdata[gmd_pkg::CELL_OPEN]};
        sw_d      = sw_q + NW'(1);
        if (sw_q == NW'(gmd_pkg::CELLS)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start_addr;
          cnt_d     = NW'(1);
          pos_d     = start_addr;
          status_d  = gmd_pkg::ST_LOOKING;
        end
      end
      gmd_pkg::S_POP: begin
        pos_d = stk_rdata;
        if (stk_rdata == {exit_y_q, exit_x_q}) status_d = gmd_pkg::ST_FREEDOM;
      end
      gmd_pkg::S_NBR: begin
        // issue the read of neighbour nb_q
        map_raddr  = {ny[CW-1:0], nx[CW-1:0]};
        chk_v_d    = (nb_q != gmd_pkg::NBR_W'(gmd_pkg::NBR_CNT));
        chk_ok_d   = n_ok;
        chk_addr_d = {ny[CW-1:0], nx[CW-1:0]};
        if (chk_v_d) nb_d = nb_q + gmd_pkg::NBR_W'(1);
        // mark and push the neighbour read last cycle
        if (nbr_push) begin
          map_we    = 1'b1;
          map_waddr = chk_addr_q;
          map_wdata = '1;
          if (cnt_q != NW'(gmd_pkg::CELLS)) begin
            stk_we = 1'b1;
            cnt_d  = cnt_q + NW'(1);
          end
        end
      end
      gmd_pkg::S_DONE: begin
        if (res_free) begin
          res_vld_d    = 1'b1;
          res_status_d = status_q;
          res_pos_d    = pos_q;
          res_cnt_d    = cnt_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gmd_pkg::S_CLEAR;
      status_q  <= gmd_pkg::ST_LOOKING;
      sw_q      <= '0;
      nb_q      <= '0;
      chk_v_q   <= 1'b0;
      pos_q     <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      sw_q      <= sw_d;
      nb_q      <= nb_d;
      chk_v_q   <= chk_v_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_ok_q     <= chk_ok_d;
    chk_addr_q   <= chk_addr_d;
    ld_addr_q    <= ld_addr_d;
    ld_open_q    <= ld_open_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_cnt_q    <= res_cnt_d;
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DW'(gmd_pkg::MAX_DIM);
      height_q  <= DW'(gmd_pkg::MAX_DIM);
      exit_x_q  <= '0;
      exit_y_q  <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gmd_pkg::REG_MAZE_WIDTH:  width_q   <= cfg_i.data;
        gmd_pkg::REG_MAZE_HEIGHT: height_q  <= cfg_i.data;
        gmd_pkg::REG_EXIT_X:      exit_x_q  <= cfg_i.data[CW-1:0];
        gmd_pkg::REG_EXIT_Y:      exit_y_q  <= cfg_i.data[CW-1:0];
        gmd_pkg::REG_START_X:     start_x_q <= cfg_i.data[CW-1:0];
        gmd_pkg::REG_START_Y:     start_y_q <= cfg_i.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // port drive
  assign cfg_i.ready   = 1'b1;
  assign cmd_i.ready   = (state_q == gmd_pkg::S_IDLE);
  assign res_o.valid   = res_vld_q;
  assign res_o.status  = res_status_q;
  assign res_o.pos_x   = res_pos_q[CW-1:0];
  assign res_o.pos_y   = res_pos_q[AW-1:CW];
  assign res_o.pending = res_cnt_q;

endmodule

// ----- sim/tb_grid_maze_dfs_step.sv -----
// ----------------------------------------------------------------------------
// tb_grid_maze_dfs_step
// Self-checking bench for the grid maze depth-first walker. A directed part
// covers the edge cases, then randomized mazes are loaded, searched and mostly
// stepped past their end. Each result word is compared against a local
// walker model under changing idle patterns and a long result back-pressure.
// ----------------------------------------------------------------------------
module tb_grid_maze_dfs_step;

  localparam logic [gmd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RUN_ITEMS    = 1850;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [gmd_pkg::CMD_W-1:0]   command;
    logic [gmd_pkg::COORD_W-1:0] cx;
    logic [gmd_pkg::COORD_W-1:0] cy;
    logic                        open;
  } cmd_word_t;

  typedef struct packed {
    gmd_pkg::status_e            status;
    logic [gmd_pkg::COORD_W-1:0] px;
    logic [gmd_pkg::COORD_W-1:0] py;
    logic [gmd_pkg::CNT_W-1:0]   pending;
  } res_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gmd_cmd_if cmd_if ();
  gmd_res_if res_if ();
  gmd_cfg_if cfg_if ();

  grid_maze_dfs_step DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // walker model state
  logic                        open_m [gmd_pkg::CELLS];
  logic                        seen_m [gmd_pkg::CELLS];
  logic [gmd_pkg::ADDR_W-1:0]  trail  [gmd_pkg::CELLS];
  int                          trail_n = 0;
  logic [gmd_pkg::COORD_W-1:0] walk_x = '0;
  logic [gmd_pkg::COORD_W-1:0] walk_y = '0;
  gmd_pkg::status_e            walk_st = gmd_pkg::ST_LOOKING;
  logic [gmd_pkg::DIM_W-1:0]   cfg_w = gmd_pkg::DIM_W'(gmd_pkg::MAX_DIM);
  logic [gmd_pkg::DIM_W-1:0]   cfg_h = gmd_pkg::DIM_W'(gmd_pkg::MAX_DIM);
  logic [gmd_pkg::COORD_W-1:0] cfg_ex = '0;
  logic [gmd_pkg::COORD_W-1:0] cfg_ey = '0;
  logic [gmd_pkg::COORD_W-1:0] cfg_sx = '0;
  logic [gmd_pkg::COORD_W-1:0] cfg_sy = '0;

  // bench bookkeeping
  cmd_word_t pending_cmds [$];
  res_word_t expected_words [$];
  int  items_pushed = 0;
  int  words_checked = 0;
  int  errors = 0;
  int  cycle_count = 0;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  hold_asks = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  bit  cmd_fire = 1'b0;
  bit  cfg_fire = 1'b0;

  initial begin
    for (int i = 0; i < gmd_pkg::CELLS; i++) begin
      open_m[i] = 1'b0;
      seen_m[i] = 1'b0;
      trail[i]  = '0;
    end
  end

  // mark and push one neighbour if it is usable and not yet visited
  function automatic void visit_neighbour(input int nx, input int ny);
    int idx;
    if (nx >= 0 && ny >= 0 && nx < gmd_pkg::MAX_DIM && ny < gmd_pkg::MAX_DIM &&
        nx < int'(cfg_w) && ny < int'(cfg_h)) begin
      idx = ny * gmd_pkg::MAX_DIM + nx;
      if (open_m[idx] && !seen_m[idx]) begin
        seen_m[idx] = 1'b1;
        if (trail_n < gmd_pkg::CELLS) begin
          trail[trail_n] = {gmd_pkg::COORD_W'(ny), gmd_pkg::COORD_W'(nx)};
          trail_n++;
        end
      end
    end
  endfunction

  // apply one command to the walker model and return the result word
  function automatic res_word_t advance_walker(input cmd_word_t c);
    int px;
    int py;
    res_word_t r;
    case (c.command)
      gmd_pkg::CMD_LOAD: open_m[{c.cy, c.cx}] = c.open;
      gmd_pkg::CMD_START: begin
        for (int i = 0; i < gmd_pkg::CELLS; i++) seen_m[i] = 1'b0;
        seen_m[{cfg_sy, cfg_sx}] = 1'b1;
        trail[0] = {cfg_sy, cfg_sx};
        trail_n  = 1;
        walk_x   = cfg_sx;
        walk_y   = cfg_sy;
        walk_st  = gmd_pkg::ST_LOOKING;
      end
      gmd_pkg::CMD_STEP: begin
        if (trail_n == 0) begin
          walk_st = gmd_pkg::ST_STUCK;
        end else begin
          trail_n--;
          {walk_y, walk_x} = trail[trail_n];
          if (walk_x == cfg_ex && walk_y == cfg_ey) begin
            walk_st = gmd_pkg::ST_FREEDOM;
          end else begin
            px = int'(walk_x);
            py = int'(walk_y);
            if (px > 0) visit_neighbour(px - 1, py);
            visit_neighbour(px + 1, py);
            if (py > 0) visit_neighbour(px, py - 1);
            visit_neighbour(px, py + 1);
          end
        end
      end
      default: ;
    endcase
    r.status  = walk_st;
    r.px      = walk_x;
    r.py      = walk_y;
    r.pending = gmd_pkg::CNT_W'(trail_n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at word %0d: %s got %0d expected %0d", words_checked, what, got,
               want);
  endtask

  // monitor: check result words, predict accepted command words
  always @(posedge clk_i) begin
    res_word_t want;
    cmd_word_t got_cmd;
    cmd_fire = rst_ni && cmd_if.valid && cmd_if.ready;
    cfg_fire = rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", 0, 0);
      end else begin
        want = expected_words.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", int'(res_if.status), int'(want.status));
        if (res_if.pos_x !== want.px)
          report_mismatch("pos_x", int'(res_if.pos_x), int'(want.px));
        if (res_if.pos_y !== want.py)
          report_mismatch("pos_y", int'(res_if.pos_y), int'(want.py));
        if (res_if.pending !== want.pending)
          report_mismatch("pending", int'(res_if.pending), int'(want.pending));
      end
      words_checked++;
    end
    if (cmd_fire) begin
      got_cmd.command = cmd_if.command;
      got_cmd.cx      = cmd_if.cell_x;
      got_cmd.cy      = cmd_if.cell_y;
      got_cmd.open    = cmd_if.cell_open;
      expected_words.push_back(advance_walker(got_cmd));
    end
  end

  // long result hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_asks;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // driver: command words from the queue, random result stalls
  always @(negedge clk_i) begin
    cmd_word_t nxt;
    if (rst_ni) begin
      if (!cmd_if.valid || cmd_fire) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_cmds.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.command   <= nxt.command;
          cmd_if.cell_x    <= nxt.cx;
          cmd_if.cell_y    <= nxt.cy;
          cmd_if.cell_open <= nxt.open;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic queue_cmd(input logic [gmd_pkg::CMD_W-1:0] c, input int x, input int y,
                           input bit o);
    cmd_word_t w;
    w.command = c;
    w.cx      = gmd_pkg::COORD_W'(x);
    w.cy      = gmd_pkg::COORD_W'(y);
    w.open    = o;
    pending_cmds.push_back(w);
    items_pushed++;
  endtask

  // one stray word between the regular ones
  task automatic queue_noise();
    int r;
    r = $urandom_range(7);
    if (r <= 2)
      queue_cmd(gmd_pkg::CMD_LOAD, $urandom_range(63), $urandom_range(63),
                $urandom_range(1));
    else if (r <= 4)
      queue_cmd(CMD_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(1));
    else if (r <= 6)
      queue_cmd(gmd_pkg::CMD_STEP, $urandom_range(63), $urandom_range(63),
                $urandom_range(1));
    else
      queue_cmd(gmd_pkg::CMD_START, $urandom_range(63), $urandom_range(63),
                $urandom_range(1));
  endtask

  // wait until every queued word has its result back
  task automatic wait_drained();
    do @(negedge clk_i); while (words_checked < items_pushed);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input gmd_pkg::cfg_reg_e idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= gmd_pkg::CFG_DATA_W'(value);
    do @(negedge clk_i); while (!cfg_fire);
    case (idx)
      gmd_pkg::REG_MAZE_WIDTH:  cfg_w  = gmd_pkg::DIM_W'(value);
      gmd_pkg::REG_MAZE_HEIGHT: cfg_h  = gmd_pkg::DIM_W'(value);
      gmd_pkg::REG_EXIT_X:      cfg_ex = gmd_pkg::COORD_W'(value);
      gmd_pkg::REG_EXIT_Y:      cfg_ey = gmd_pkg::COORD_W'(value);
      gmd_pkg::REG_START_X:     cfg_sx = gmd_pkg::COORD_W'(value);
      gmd_pkg::REG_START_Y:     cfg_sy = gmd_pkg::COORD_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_maze(input int w, input int h, input int ex, input int ey,
                          input int sx, input int sy);
    write_reg(gmd_pkg::REG_MAZE_WIDTH, w);
    write_reg(gmd_pkg::REG_MAZE_HEIGHT, h);
    write_reg(gmd_pkg::REG_EXIT_X, ex);
    write_reg(gmd_pkg::REG_EXIT_Y, ey);
    write_reg(gmd_pkg::REG_START_X, sx);
    write_reg(gmd_pkg::REG_START_Y, sy);
    cfg_if.valid <= 1'b0;
  endtask

  // one random maze: geometry, map load, start, steps
  task automatic run_search(input int idx);
    int w, h, sx, sy, ex, ey, r, open_pct, n_steps;
    case (idx % 4)
      0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      1: begin src_idle_pct = 48; snk_idle_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_idle_pct = 48; end
      default: begin src_idle_pct = 10; snk_idle_pct = 10; end
    endcase
    r = $urandom_range(9);
    if (r == 0) begin
      w = gmd_pkg::MAX_DIM;
      h = $urandom_range(1, 2);
    end else if (r == 1) begin
      w = $urandom_range(1, 2);
      h = gmd_pkg::MAX_DIM;
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end
    sx = $urandom_range(w - 1);
    sy = $urandom_range(h - 1);
    if ($urandom_range(9) == 0) begin
      sx = $urandom_range(63);
      sy = $urandom_range(63);
    end
    ex = $urandom_range(w - 1);
    ey = $urandom_range(h - 1);
    if ($urandom_range(4) == 0) begin
      ex = $urandom_range(63);
      ey = $urandom_range(63);
    end
    wait_drained();
    set_maze(w, h, ex, ey, sx, sy);
    // back-pressure while the map streams in
    if (idx == 4 || idx == 12) hold_asks++;
    // map load including one row and one column beyond the used area
    open_pct = $urandom_range(50, 85);
    for (int y = 0; y <= h && y < gmd_pkg::MAX_DIM; y++)
      for (int x = 0; x <= w && x < gmd_pkg::MAX_DIM; x++) begin
        queue_cmd(gmd_pkg::CMD_LOAD, x, y, $urandom_range(99) < open_pct);
        if ($urandom_range(99) < 4) queue_noise();
      end
    queue_cmd(gmd_pkg::CMD_START, $urandom_range(63), $urandom_range(63),
              $urandom_range(1));
    // mostly enough steps to run out of points, sometimes cut short
    if ($urandom_range(4) == 0) n_steps = $urandom_range(1, w * h);
    else n_steps = w * h + 2;
    for (int s = 0; s < n_steps; s++) begin
      queue_cmd(gmd_pkg::CMD_STEP, $urandom_range(63), $urandom_range(63),
                $urandom_range(1));
      if ($urandom_range(99) < 4) queue_noise();
    end
  endtask

  // stimulus
  initial begin
    int directed_n;
    int search_idx;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = gmd_pkg::CMD_LOAD;
    cmd_if.cell_x    = '0;
    cmd_if.cell_y    = '0;
    cmd_if.cell_open = 1'b0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = gmd_pkg::REG_MAZE_WIDTH;
    cfg_if.data      = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: step on empty stack, unused code, exit at the start cell
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_UNUSED, 63, 63, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 0, 0, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 1, 0, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 0, 1, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 63, 63, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 62, 63, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 63, 62, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 5, 5, 1);
    queue_cmd(gmd_pkg::CMD_LOAD, 5, 5, 0);
    queue_cmd(gmd_pkg::CMD_START, 0, 0, 0);
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);
    queue_cmd(CMD_UNUSED, 0, 0, 0);

    // far corner: neighbours beyond the array edge, unreachable exit
    wait_drained();
    set_maze(gmd_pkg::MAX_DIM, gmd_pkg::MAX_DIM, 63, 0, 63, 63);
    queue_cmd(gmd_pkg::CMD_START, 0, 0, 0);
    repeat (4) queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);

    // single-cell maze: open neighbours outside width and height
    wait_drained();
    set_maze(1, 1, 63, 63, 0, 0);
    queue_cmd(gmd_pkg::CMD_START, 0, 0, 0);
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);

    // start on a wall cell
    wait_drained();
    set_maze(gmd_pkg::MAX_DIM, gmd_pkg::MAX_DIM, 0, 0, 5, 5);
    queue_cmd(gmd_pkg::CMD_START, 0, 0, 0);
    queue_cmd(gmd_pkg::CMD_STEP, 0, 0, 0);
    directed_n = items_pushed;

    // random mazes
    search_idx = 0;
    while (items_pushed < directed_n + RUN_ITEMS) begin
      run_search(search_idx);
      search_idx++;
    end

    do @(negedge clk_i); while (words_checked < items_pushed);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && expected_words.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gmd_pkg.sv
rtl/gmd_if.sv
rtl/gmd_ram.sv
rtl/grid_maze_dfs_step.sv
sim/tb_grid_maze_dfs_step.sv
